// ===== design/bdpt_pkg.sv =====
// Package for the button debounce / press timer block.
// Shared types, widths and stream field positions; no dependencies.

package bdpt_pkg;

    // Width of the internal time base; times and differences wrap at this width.
    localparam int TIME_WIDTH = 32;
    localparam int CMP_WIDTH  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    // Input stream packing: now_ms, raw_level, zero fill to whole bytes
    localparam int NOW_LSB    = 0;
    localparam int RAW_BIT    = 32;
    localparam int S_BITS     = 33;
    localparam int S_DATA_W   = ((S_BITS + 7) / 8) * 8;

    // Output stream packing, lowest bit first
    localparam int SETTLED_BIT = 0;
    localparam int STABLE_BIT  = 1;
    localparam int PRESS_BIT   = 2;
    localparam int RELEASE_BIT = 3;
    localparam int PHASE_LSB   = 4;
    localparam int PHASE_MSB   = 35;
    localparam int LPRESS_BIT  = 36;
    localparam int LREL_BIT    = 37;
    localparam int M_BITS      = 38;
    localparam int M_DATA_W    = ((M_BITS + 7) / 8) * 8;

    // Configuration register map
    localparam int          ADDR_W          = 4;
    localparam logic [1:0]  REG_PRESSED_LVL = 2'd0;
    localparam logic [1:0]  REG_DEBOUNCE    = 2'd1;
    localparam logic [1:0]  REG_LONG_PRESS  = 2'd2;
    localparam logic [1:0]  REG_LONG_REL    = 2'd3;

    localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [31:0] LONG_PRESS_RST  = 32'd1000;
    localparam logic [31:0] LONG_REL_RST    = 32'd1000;

    typedef struct packed {
        logic        pressed_level;
        logic [15:0] debounce_ms;
        logic [31:0] long_press_ms;
        logic [31:0] long_release_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        raw_level;
    } item_t;

    typedef struct packed {
        logic        settled;
        logic        stable_level;
        logic        press_event;
        logic        release_event;
        logic [31:0] phase_ms;
        logic        long_press_event;
        logic        long_release_event;
    } result_t;

endpackage

// ===== design/button_debounce_press_timer_top.sv =====
// Top level of the button debounce / press timer block.
// Input register, step logic and result register; uses bdpt_pkg, bdpt_cfg_regs, bdpt_core.
//
//   Group   Dir  Handshake              Contents
//   s_*     in   s_tvalid / s_tready    now_ms, raw_level
//   m_*     out  m_tvalid / m_tready    one result per sample
//   APB     in   psel & penable         four config registers, 4-byte stride
//
// One sample per cycle sustained while m_tready is high; a result passes the sample register, then the result register.
// The sample register feeds the step logic; state and result register load together.
// s_tready stays high while the result register can drain or is empty.
// Reset clears state to the released level, times to 0, registers to defaults.

module button_debounce_press_timer_top
    import bdpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // samples in
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // now_ms[31:0], raw_level[32], zero fill
    // results out
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // settled, stable_level, press_event,
                                           // release_event, phase_ms[35:4],
                                           // long_press_event, long_release_event
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t res;
    result_t res_reg;
    logic    advance;

    bdpt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdpt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item_reg),
        .result (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.now_ms    <= s_tdata[NOW_LSB +: 32];
            item_reg.raw_level <= s_tdata[RAW_BIT];
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata                         = '0;
        m_tdata[SETTLED_BIT]            = res_reg.settled;
        m_tdata[STABLE_BIT]             = res_reg.stable_level;
        m_tdata[PRESS_BIT]              = res_reg.press_event;
        m_tdata[RELEASE_BIT]            = res_reg.release_event;
        m_tdata[PHASE_MSB:PHASE_LSB]    = res_reg.phase_ms;
        m_tdata[LPRESS_BIT]             = res_reg.long_press_event;
        m_tdata[LREL_BIT]               = res_reg.long_release_event;
    end

endmodule

// ===== design/bdpt_cfg_regs.sv =====
// Configuration register file for the button debounce / press timer block.
// APB-style write/read port; depends on bdpt_pkg.

module bdpt_cfg_regs
    import bdpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PRESSED_LVL: cfg_next.pressed_level   = pwdata[0];
                REG_DEBOUNCE:    cfg_next.debounce_ms     = pwdata[15:0];
                REG_LONG_PRESS:  cfg_next.long_press_ms   = pwdata;
                REG_LONG_REL:    cfg_next.long_release_ms = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressed_level   <= 1'b0;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.long_press_ms   <= LONG_PRESS_RST;
            cfg_reg.long_release_ms <= LONG_REL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PRESSED_LVL: prdata = {31'd0, cfg_reg.pressed_level};
            REG_DEBOUNCE:    prdata = {16'd0, cfg_reg.debounce_ms};
            REG_LONG_PRESS:  prdata = cfg_reg.long_press_ms;
            REG_LONG_REL:    prdata = cfg_reg.long_release_ms;
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bdpt_core.sv =====
// Debounce and phase timing state with the per-sample update logic.
// One sample is evaluated combinationally and committed on step; depends on bdpt_pkg.

module bdpt_core
    import bdpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic                  last_raw_reg,       last_raw_next;
    logic [TIME_WIDTH-1:0] change_time_reg,    change_time_next;
    logic                  accepted_reg,       accepted_next;
    logic [TIME_WIDTH-1:0] press_start_reg,    press_start_next;
    logic [TIME_WIDTH-1:0] release_start_reg,  release_start_next;
    logic                  lp_fired_reg,       lp_fired_next;
    logic                  lr_fired_reg,       lr_fired_next;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] since_press;
    logic [TIME_WIDTH-1:0] since_release;
    logic [TIME_WIDTH-1:0] press_len;
    logic [TIME_WIDTH-1:0] release_len;
    logic [TIME_WIDTH-1:0] phase;
    logic                  settled;
    logic                  flip;
    logic                  to_pressed;
    logic                  press_long;
    logic                  release_long;

    assign now              = TIME_WIDTH'(item.now_ms);
    assign change_time_next = (item.raw_level != last_raw_reg) ? now : change_time_reg;
    assign last_raw_next    = item.raw_level;

    // all differences wrap at the time width
    assign since_change  = now - change_time_next;
    assign since_press   = now - press_start_reg;
    assign since_release = now - release_start_reg;

    assign settled    = since_change >= TIME_WIDTH'(cfg.debounce_ms);
    assign flip       = settled && (accepted_reg != item.raw_level);
    assign to_pressed = item.raw_level == cfg.pressed_level;

    assign accepted_next      = flip ? item.raw_level : accepted_reg;
    assign press_start_next   = (flip && to_pressed)  ? change_time_next : press_start_reg;
    assign release_start_next = (flip && !to_pressed) ? change_time_next : release_start_reg;

    // a new phase starts at the raw change, so its length is since_change
    assign press_len   = (flip && to_pressed)  ? since_change : since_press;
    assign release_len = (flip && !to_pressed) ? since_change : since_release;

    assign press_long   = (accepted_next == cfg.pressed_level) &&
                          (CMP_WIDTH'(press_len) > CMP_WIDTH'(cfg.long_press_ms));
    assign release_long = (accepted_next != cfg.pressed_level) &&
                          (CMP_WIDTH'(release_len) > CMP_WIDTH'(cfg.long_release_ms));

    assign lp_fired_next = settled ? press_long   : lp_fired_reg;
    assign lr_fired_next = settled ? release_long : lr_fired_reg;

    // ended phase: the release phase on a press, the press phase on a release
    assign phase = !flip ? '0 : (to_pressed ? since_release : since_press);

    always_comb
    begin
        result.settled            = settled;
        result.stable_level       = accepted_next;
        result.press_event        = flip && to_pressed;
        result.release_event      = flip && !to_pressed;
        result.phase_ms           = 32'(phase);
        result.long_press_event   = settled && press_long && !lp_fired_reg;
        result.long_release_event = settled && release_long && !lr_fired_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg      <= 1'b1;
            accepted_reg      <= 1'b1;
            change_time_reg   <= '0;
            press_start_reg   <= '0;
            release_start_reg <= '0;
            lp_fired_reg      <= 1'b0;
            lr_fired_reg      <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg      <= last_raw_next;
            accepted_reg      <= accepted_next;
            change_time_reg   <= change_time_next;
            press_start_reg   <= press_start_next;
            release_start_reg <= release_start_next;
            lp_fired_reg      <= lp_fired_next;
            lr_fired_reg      <= lr_fired_next;
        end
    end

endmodule

// ===== design/bdpt_checker.sv =====
// Port-level checks for the button debounce / press timer block, bound to the top.
// Depends on bdpt_pkg for the result field positions.

module bdpt_checker
    import bdpt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[PRESS_BIT] && m_tdata[RELEASE_BIT]))
        else $error("press and release in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[PRESS_BIT] || m_tdata[RELEASE_BIT] ||
                     m_tdata[LPRESS_BIT] || m_tdata[LREL_BIT]) |-> m_tdata[SETTLED_BIT])
        else $error("event inside the debounce window");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[PRESS_BIT] && !m_tdata[RELEASE_BIT]
            |-> m_tdata[PHASE_MSB:PHASE_LSB] == '0)
        else $error("phase length without an edge event");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[LPRESS_BIT] && m_tdata[LREL_BIT]))
        else $error("long press and long release together");

endmodule

bind button_debounce_press_timer_top bdpt_checker u_bdpt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
